// ----- rtl/olqe_pkg.sv -----
package olqe_pkg;

  typedef logic [2:0]         opcode_t;
  typedef logic signed [15:0] value_t;
  typedef logic [4:0]         count_t;
  typedef logic [1:0]         err_t;

  localparam opcode_t OP_PUSH   = 3'd0;
  localparam opcode_t OP_POP    = 3'd1;
  localparam opcode_t OP_DELETE = 3'd2;
  localparam opcode_t OP_ADD    = 3'd3;
  localparam opcode_t OP_CLEAR  = 3'd4;
  localparam opcode_t OP_QUERY  = 3'd5;

  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_PUSH_FULL = 2'd1;
  localparam err_t ERR_POP_EMPTY = 2'd2;

endpackage

// ----- rtl/ordered_list_queue_engine.sv -----
// Ordered queue of up to DEPTH signed 16-bit entries with delete-by-value.
// Input channel (in_valid/in_ready): one beat carries opcode and
// operand_value. Output channel (out_valid/out_ready): one beat per input
// beat with front, back, count, empty, match and error fields describing
// the queue after the operation.
// Entries sit in a circular buffer in a single-port-write, single-read
// memory; one shared read/compare/add datapath walks it one entry a cycle.
// Push, pop, clear and query pass through the READF, READB and FIN steps
// after accept. Delete and add-to-all first walk every held entry
// through that datapath in SCAN. A new beat is taken in the cycle after
// the previous result is registered.
// A result that is not taken leaves the output register full; the next
// beat is still accepted and worked on, and its result waits in the final
// step until the register frees.
// Reset empties the queue and clears out_valid; memory contents are not
// cleared, as only held entries are ever read.
module ordered_list_queue_engine #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  olqe_pkg::opcode_t opcode,
  input  olqe_pkg::value_t operand_value,
  output logic             out_valid,
  input  logic             out_ready,
  output olqe_pkg::value_t front_value,
  output olqe_pkg::value_t back_value,
  output olqe_pkg::count_t entry_count,
  output logic             is_empty,
  output logic             match_found,
  output olqe_pkg::err_t   error_code
);
  import olqe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READF = 3'd2;
  localparam logic [2:0] S_READB = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state;
  opcode_t       op_q;
  value_t        val_q;
  logic [PW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic          pend;
  logic [PW-1:0] pend_idx;
  logic          found;
  err_t          err_q;
  value_t        front_q;

  value_t        mem [DEPTH];
  value_t        rd_data;
  logic [PW-1:0] rd_addr;
  logic          we;
  logic [PW-1:0] wa;
  value_t        wd;
  logic          issue;
  logic          accept;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [PW-1:0] idx);
    logic [PW:0] s;
    s = {1'b0, h} + {1'b0, idx};
    if (s >= (PW+1)'(DEPTH)) s = s - (PW+1)'(DEPTH);
    return s[PW-1:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (rd_idx < count);

  always_comb begin
    rd_addr = head;
    unique case (state)
      S_SCAN:         rd_addr = phys(head, rd_idx[PW-1:0]);
      S_READB, S_FIN: rd_addr = (count == '0) ? head
                                : phys(head, PW'(count - CW'(1)));
      default:        rd_addr = head;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = phys(head, PW'(count));
    wd = operand_value;
    if (accept && opcode == OP_PUSH && count != CW'(DEPTH)) begin
      we = 1'b1;
    end else if (state == S_SCAN && pend) begin
      if (op_q == OP_ADD) begin
        we = 1'b1;
        wa = phys(head, pend_idx);
        wd = rd_data + val_q;
      end else begin
        we = found;
        wa = phys(head, pend_idx - PW'(1));
        wd = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      found     <= 1'b0;
      pend      <= 1'b0;
      rd_idx    <= '0;
      err_q     <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q   <= opcode;
            val_q  <= operand_value;
            found  <= 1'b0;
            pend   <= 1'b0;
            rd_idx <= '0;
            unique case (opcode)
              OP_PUSH: begin
                state <= S_READF;
                if (count == CW'(DEPTH)) begin
                  err_q <= ERR_PUSH_FULL;
                end else begin
                  err_q <= ERR_NONE;
                  count <= count + CW'(1);
                end
              end
              OP_POP: begin
                state <= S_READF;
                if (count == '0) begin
                  err_q <= ERR_POP_EMPTY;
                end else begin
                  err_q <= ERR_NONE;
                  head  <= phys(head, PW'(1));
                  count <= count - CW'(1);
                end
              end
              OP_DELETE, OP_ADD: begin
                state <= S_SCAN;
                err_q <= ERR_NONE;
              end
              OP_CLEAR: begin
                state <= S_READF;
                err_q <= ERR_NONE;
                count <= '0;
                head  <= '0;
              end
              default: begin
                state <= S_READF;
                err_q <= ERR_NONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) rd_idx <= rd_idx + CW'(1);
          pend     <= issue;
          pend_idx <= rd_idx[PW-1:0];
          if (pend && op_q == OP_DELETE && !found && rd_data == val_q) begin
            found <= 1'b1;
          end
          if (!issue && !pend) begin
            state <= S_READF;
            if (found) count <= count - CW'(1);
          end
        end
        S_READF: state <= S_READB;
        S_READB: begin
          front_q <= rd_data;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            front_value <= (count == '0) ? '0 : front_q;
            back_value  <= (count == '0) ? '0 : rd_data;
            entry_count <= 5'(count);
            is_empty    <= (count == '0);
            match_found <= found;
            error_code  <= err_q;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second beat taken while busy");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_PUSH && count == CW'(DEPTH)) |=>
      (count == CW'(DEPTH) && err_q == ERR_PUSH_FULL))
    else $error("push while full altered queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_POP && count == '0) |=>
      (count == '0 && err_q == ERR_POP_EMPTY))
    else $error("pop while empty not flagged");

  a_found_delete: assert property (@(posedge clk) disable iff (rst)
    found |-> (op_q == OP_DELETE))
    else $error("match flag outside delete");
`endif

endmodule
